@@ rtl/windowed_frame_rate_meter_unit_macros.svh @@
// Assertion macros for the windowed frame rate meter.
// Included by the top level; has no other dependencies.
`ifndef WINDOWED_FRAME_RATE_METER_UNIT_MACROS_SVH
`define WINDOWED_FRAME_RATE_METER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define FRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define FRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/frm_pkg.sv @@
// Shared types and constants of the windowed frame rate meter.
// No dependencies; used by frm_divider and the top level.
package frm_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned RATE_W = 23;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned CNT_W  = $clog2(TIME_W);

  localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(1000);
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  // The scale factor 1000 is applied as 1024 - 16 - 8, so the serial
  // product taps the difference stream 10, 4 and 3 bits back.
  localparam int unsigned TAP_POS  = 9;
  localparam int unsigned TAP_NEG1 = 3;
  localparam int unsigned TAP_NEG2 = 2;
  localparam int unsigned HIST_W   = TAP_POS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } frm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/frm_divider.sv @@
// Restoring unsigned divider producing one quotient bit per cycle.
// Depends on frm_pkg.
module frm_divider
  import frm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [TIME_W-1:0] quotient_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] rem_q, quo_q, dvs_q;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try to subtract.
  assign trial = {rem_q, quo_q[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = ~diff[TIME_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TIME_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ rtl/windowed_frame_rate_meter_unit.sv @@
// Windowed frame rate meter: one result per frame event with the current rate.
// Each event is scanned serially; when its window closes, a new rate is then
// divided out. One event is in flight, so a new event is taken only after the
// previous result is loaded into the output register, which waits out any
// receiver stall.
// Asynchronous active-low reset clears counters, window start and rate; window 1000.
`include "windowed_frame_rate_meter_unit_macros.svh"

module windowed_frame_rate_meter_unit
  import frm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: window_length_ms[15:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input stream, tdata: now_ms[31:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Output stream, tdata: rate_per_second[22:0], zero pad [23]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // Output stream, tuser: rate_updated[0]
  output logic [0:0]  m_axis_tuser
);

  frm_state_e state_q, state_d;

  // Architectural state. The counters and time stamps rotate through bit 0
  // during the scan and are back in place, the event total incremented, at its end.
  logic [WIN_W-1:0]  wl_q;
  logic [TIME_W-1:0] et_q, wse_q, wst_q;
  logic [RATE_W-1:0] rate_q;

  // Per-event working registers.
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] now_q;     // rotated like the state, so it survives the scan
  logic [TIME_W-1:0] el_q;      // elapsed time, filled LSB first
  logic [TIME_W-1:0] sc_q;      // scaled event count, filled LSB first
  logic [WIN_W-1:0]  wls_q;     // window length, shifted out LSB first
  logic [HIST_W-1:0] hist_q;    // recent bits of the event difference
  logic              inc_c_q, db_q, eb_q, gt_q, upd_q;
  logic [1:0]        sb_q;

  // Output register.
  logic              m_valid_q, m_upd_q;
  logic [RATE_W-1:0] m_rate_q;

  // Serial bit logic for one scan cycle.
  logic       inc_bit, inc_c_n;
  logic       d_bit, db_n;
  logic       e_bit, eb_n;
  logic       gt_n;
  logic [2:0] s_sum;
  logic       s_bit;
  logic [1:0] sb_n;

  logic              s_xfer, m_xfer, out_free, scan_last;
  logic              div_start;
  div_stat_t         div_stat;
  logic [TIME_W-1:0] quotient;
  logic [RATE_W-1:0] rate_sat;

  assign cfg_ready_o = 1'b1;
  assign s_xfer      = s_axis_tvalid & s_axis_tready;
  assign m_xfer      = m_valid_q & m_axis_tready;
  assign out_free    = ~m_valid_q | m_axis_tready;
  assign scan_last   = (cnt_q == CNT_W'(TIME_W - 1));

  // Increment of the event total, one bit per cycle.
  assign inc_bit = et_q[0] ^ inc_c_q;
  assign inc_c_n = et_q[0] & inc_c_q;

  // Events in the window: new total minus the total at window start.
  assign d_bit = inc_bit ^ wse_q[0] ^ db_q;
  assign db_n  = (~inc_bit & (wse_q[0] | db_q)) | (wse_q[0] & db_q);

  // Elapsed time, modulo 2^32.
  assign e_bit = now_q[0] ^ wst_q[0] ^ eb_q;
  assign eb_n  = (~now_q[0] & (wst_q[0] | eb_q)) | (wst_q[0] & eb_q);

  // Serial compare: the highest differing bit seen so far decides.
  assign gt_n = (e_bit != wls_q[0]) ? e_bit : gt_q;

  // Times 1000 as d<<10 - d<<4 - d<<3. The sum is offset by four so it
  // stays non-negative; the borrow into the next bit is then 2 - sum/2.
  assign s_sum = {2'b00, hist_q[TAP_POS]} + 3'd4 - {2'b00, hist_q[TAP_NEG1]}
               - {2'b00, hist_q[TAP_NEG2]} - {1'b0, sb_q};
  assign s_bit = s_sum[0];
  assign sb_n  = 2'd2 - s_sum[2:1];

  // Quotients that do not fit the rate field saturate.
  assign rate_sat = (|quotient[TIME_W-1:RATE_W]) ? RATE_MAX : quotient[RATE_W-1:0];

  frm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sc_q),
    .divisor_i  (el_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Control: idle, serial scan, decision, optional divide, result hand-off.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (gt_q) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window length register and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WIN_RESET;
      et_q   <= '0;
      wse_q  <= '0;
      wst_q  <= '0;
      rate_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        wl_q <= cfg_data_i;
      end
      if (state_q == ST_SCAN) begin
        et_q  <= {inc_bit, et_q[TIME_W-1:1]};
        wse_q <= {wse_q[0], wse_q[TIME_W-1:1]};
        wst_q <= {wst_q[0], wst_q[TIME_W-1:1]};
      end else if (state_q == ST_DIVIDE && div_stat.done) begin
        // Close the window: new start at this event and this time.
        wse_q  <= et_q;
        wst_q  <= now_q;
        rate_q <= rate_sat;
      end
    end
  end

  // Working registers of the scan.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      now_q   <= s_axis_tdata;
      wls_q   <= wl_q;
      hist_q  <= '0;
      inc_c_q <= 1'b1;
      db_q    <= 1'b0;
      eb_q    <= 1'b0;
      sb_q    <= '0;
      gt_q    <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      now_q   <= {now_q[0], now_q[TIME_W-1:1]};
      wls_q   <= {1'b0, wls_q[WIN_W-1:1]};
      hist_q  <= {hist_q[HIST_W-2:0], d_bit};
      el_q    <= {e_bit, el_q[TIME_W-1:1]};
      sc_q    <= {s_bit, sc_q[TIME_W-1:1]};
      inc_c_q <= inc_c_n;
      db_q    <= db_n;
      eb_q    <= eb_n;
      sb_q    <= sb_n;
      gt_q    <= gt_n;
    end
    if (state_q == ST_CHECK) begin
      upd_q <= gt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s_xfer) begin
      cnt_q <= '0;
    end else if (state_q == ST_SCAN) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Output register: a new item may be scanned while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_xfer) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      m_rate_q <= rate_q;
      m_upd_q  <= upd_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_rate_q};
  assign m_axis_tuser  = m_upd_q;

  // The divisor is an elapsed time that exceeded the window length.
  `FRM_ASSERT(a_div_nonzero, clk_i, rst_ni, div_start |-> (el_q != '0), "divide by zero")
  // The divider only runs while the control waits for it.
  `FRM_ASSERT(a_div_owned, clk_i, rst_ni, div_stat.busy |-> (state_q == ST_DIVIDE), "stray divide")
  // The decision cycle always follows a complete scan.
  `FRM_ASSERT(a_scan_full, clk_i, rst_ni,
              (state_q == ST_CHECK) |-> ($past(state_q) == ST_SCAN && cnt_q == '0),
              "scan cut short")
  // No input transfer while a result waits to be loaded.
  `FRM_ASSERT_ALWAYS(a_no_overlap, clk_i, s_axis_tready |-> (state_q != ST_FINISH),
                     "input taken during hand-off")

endmodule

@@ sim/frame_rate_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the windowed frame rate meter: tracks the window length,
// predicts one rate result per accepted frame event and compares each result.
// Depends on frm_pkg for the field widths, the reset window length and the rate ceiling.
module frame_rate_checker
  import frm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [WIN_W-1:0]  cfg_data_i,
  input  logic              event_valid_i,
  input  logic              event_ready_i,
  input  logic [TIME_W-1:0] event_time_i,
  input  logic              result_valid_i,
  input  logic              result_ready_i,
  input  logic [23:0]       result_data_i,
  input  logic [0:0]        result_flag_i,
  output int                mismatches_o,
  output int                pending_o
);

  localparam logic [TIME_W-1:0] MS_PER_SECOND = TIME_W'(1000);
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              updated;
  } rate_report_t;

  logic [WIN_W-1:0]  window_len    = WIN_RESET;
  logic [TIME_W-1:0] events_seen   = '0;
  logic [TIME_W-1:0] window_events = '0;
  logic [TIME_W-1:0] window_time   = '0;
  logic [RATE_W-1:0] held_rate     = '0;
  rate_report_t      rate_q[$];
  int                mismatches    = 0;
  int                pending       = 0;
  int                result_count  = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  // Counts one event and closes the window once the elapsed time, modulo 2^32,
  // is beyond the window length. All arithmetic wraps at 32 bits.
  function automatic rate_report_t count_event(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] scaled;
    logic [TIME_W-1:0] quotient;
    rate_report_t      report;
    events_seen    = events_seen + 1'b1;
    elapsed        = stamp - window_time;
    report.updated = 1'b0;
    if (elapsed > TIME_W'(window_len)) begin
      scaled         = (events_seen - window_events) * MS_PER_SECOND;
      quotient       = scaled / elapsed;
      held_rate      = (quotient > TIME_W'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
      window_events  = events_seen;
      window_time    = stamp;
      report.updated = 1'b1;
    end
    report.rate = held_rate;
    return report;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: result %0d: %s", $time, result_count, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rate_report_t want;
    if (!rst_ni) begin
      window_len    = WIN_RESET;
      events_seen   = '0;
      window_events = '0;
      window_time   = '0;
      held_rate     = '0;
      rate_q.delete();
      pending       = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        window_len = cfg_data_i;
      end
      if (event_valid_i && event_ready_i) begin
        rate_q.push_back(count_event(event_time_i));
      end
      if (result_valid_i && result_ready_i) begin
        if (rate_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result rate %0d updated %0d",
                                    result_data_i[RATE_W-1:0], result_flag_i[0]));
        end else begin
          want = rate_q.pop_front();
          if (result_data_i[RATE_W-1:0] !== want.rate) begin
            report_mismatch($sformatf("rate got %0d expected %0d",
                                      result_data_i[RATE_W-1:0], want.rate));
          end
          if (result_flag_i[0] !== want.updated) begin
            report_mismatch($sformatf("updated got %b expected %b",
                                      result_flag_i[0], want.updated));
          end
          if (result_data_i[23] !== 1'b0) begin
            report_mismatch("tdata pad bit is not zero");
          end
        end
        result_count++;
      end
      pending = rate_q.size();
    end
  end

endmodule

@@ sim/tb_windowed_frame_rate_meter_unit.sv @@
`timescale 1ns / 1ps
// Top of the frame rate meter testbench: clock, reset, event and config stimulus,
// a stalling result sink, the watchdog and the verdict.
// Depends on frm_pkg, windowed_frame_rate_meter_unit and frame_rate_checker.
module tb_windowed_frame_rate_meter_unit;
  import frm_pkg::*;

  localparam int RESET_CYCLES     = 12;
  localparam int LONG_HOLD        = 400;   // receiver hold-off, long enough to back up the input
  localparam int WATCHDOG_LIMIT   = 4000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES    = 100;   // beyond the latency of one event when the receiver does not stall
  localparam int RANDOM_PER_PHASE = 200;

  // Receiver behavior, picked anew at random by the result sink.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_SLOW
  } rx_mode_e;

  // How the next frame time stamp is derived from the previous one.
  typedef enum logic [2:0] {
    STEP_SMALL,
    STEP_ZERO,
    STEP_EDGE,
    STEP_BACK,
    STEP_WILD
  } step_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int          fail_count;
  int          results_owed;

  // Sender bookkeeping shared by the stimulus tasks, and the watchdog's idle count.
  int          burst_left    = 0;
  int          gap_max       = 8;
  bit          offering      = 1'b0;
  logic [31:0] last_stamp    = '0;
  int          hold_requests = 0;
  int          idle_cycles   = 0;

  windowed_frame_rate_meter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  frame_rate_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .event_valid_i  (s_axis_tvalid),
    .event_ready_i  (s_axis_tready),
    .event_time_i   (s_axis_tdata),
    .result_valid_i (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .result_data_i  (m_axis_tdata),
    .result_flag_i  (m_axis_tuser),
    .mismatches_o   (fail_count),
    .pending_o      (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Any transfer on any channel counts as progress. A stretch with none means
  // the block has hung, so the run ends as a failure.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[windowed_frame_rate_meter_unit] ERROR");
      $finish;
    end
  end

  // Result sink. It stalls on a mode of its own, picked anew at random; a hold
  // request from the stimulus makes it refuse results for a hold-off counted
  // here, so the single event slot fills and the input stalls while the
  // sender keeps offering.
  initial begin
    int       holds_seen;
    int       hold_left;
    int       mode_left;
    rx_mode_e mode;
    holds_seen    = 0;
    hold_left     = 0;
    mode_left     = 0;
    mode          = RX_ALWAYS;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
          default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one frame event and returns at the falling edge after its transfer.
  // Events go out in bursts; valid stays high across a burst and drops only
  // for a gap, so it is never lowered and raised at the same edge.
  task automatic send_stamp(input logic [31:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        if (offering) begin
          s_axis_tvalid <= 1'b0;
          offering = 1'b0;
        end
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    last_stamp = stamp;
  endtask

  task automatic stream_idle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic drain();
    stream_idle();
    while (results_owed != 0) @(negedge clk_i);
  endtask

  // The window length is only changed with nothing in flight.
  task automatic write_window(input logic [15:0] len);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly forward time steps of a fraction of the window, so several events
  // land in each window before it closes; the rest are repeats, steps right at
  // the window boundary, small backward steps and arbitrary stamps.
  function automatic logic [31:0] next_stamp(input logic [31:0] prev, input logic [15:0] len);
    int unsigned pick;
    step_kind_e  kind;
    pick = $urandom_range(0, 99);
    if (pick < 60)      kind = STEP_SMALL;
    else if (pick < 75) kind = STEP_ZERO;
    else if (pick < 87) kind = STEP_EDGE;
    else if (pick < 93) kind = STEP_BACK;
    else                kind = STEP_WILD;
    case (kind)
      STEP_SMALL: return prev + $urandom_range(1, len / 4 + 2);
      STEP_ZERO:  return prev;
      STEP_EDGE:  return prev + len + $urandom_range(0, 1);
      STEP_BACK:  return prev - $urandom_range(1, 100);
      default:    return $urandom;
    endcase
  endfunction

  // One setting of the window length followed by random events. With stress
  // set, the receiver is told to hold off a third of the way in, and the
  // sender stops for a full drain two thirds of the way in.
  task automatic random_phase(input logic [15:0] len, input bit stress);
    write_window(len);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (stress && i == RANDOM_PER_PHASE / 3) hold_requests++;
      if (stress && i == 2 * RANDOM_PER_PHASE / 3) drain();
      send_stamp(next_stamp(last_stamp, len));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed events under the reset window of 1000 ms. A stamp exactly one
    // window after the start does not close it; one more millisecond does.
    send_stamp(32'd0);
    send_stamp(32'd1000);
    send_stamp(32'd1001);
    send_stamp(32'd1001);
    // A jump far ahead shows as a huge elapsed value and closes the window.
    send_stamp(32'hFFFF_FFFF);
    // Elapsed wraps around zero to 1 ms, well inside the window.
    send_stamp(32'd0);
    send_stamp(32'd1000);

    // A zero window closes on any elapsed time of at least 1 ms.
    write_window(16'd0);
    send_stamp(32'd1000);
    send_stamp(32'd1001);

    // The longest window, exactly at and just past its boundary.
    write_window(16'hFFFF);
    send_stamp(32'd1001 + 32'd65535);
    send_stamp(32'd1001 + 32'd65536);
    send_stamp(32'h8000_0000);
    send_stamp(32'h7FFF_FFFF);

    // A window of 1 ms, with alternating bit patterns in the stamp.
    write_window(16'd1);
    send_stamp(32'h5555_5555);
    send_stamp(32'h5555_5556);
    send_stamp(32'h5555_5557);
    send_stamp(32'hAAAA_AAAA);
    send_stamp(32'hAAAA_AAAA);
    drain();

    random_phase(16'hFFFF, 1'b1);
    random_phase(16'd0, 1'b0);
    random_phase(16'd1, 1'b0);
    random_phase(16'($urandom_range(2, 64)), 1'b1);
    random_phase(16'($urandom_range(1, 65535)), 1'b0);
    random_phase(16'($urandom_range(100, 5000)), 1'b1);
    random_phase(WIN_RESET, 1'b0);
    random_phase(16'hFFFF, 1'b0);

    // Wait for the last results, then give any stray result time to show up.
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[windowed_frame_rate_meter_unit] OK");
    end else begin
      $display("[windowed_frame_rate_meter_unit] ERROR");
    end
    $finish;
  end

endmodule
